FILE: design/srg_pkg.sv
// srg_pkg: shared types, codes and helpers of the stepper ramp generator
// depends on nothing; used by every design module and the testbench
`timescale 1ns / 1ps
`default_nettype none

package srg_pkg;

   // request operation codes
   localparam logic [1:0] OP_STEP  = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_RAMP_SHIFT      = 3'd0;
   localparam logic [2:0] CSR_SPEED_OFFSET    = 3'd1;
   localparam logic [2:0] CSR_DECEL_REFERENCE = 3'd2;
   localparam logic [2:0] CSR_SAFE_PERIOD     = 3'd3;
   localparam logic [2:0] CSR_GEN_ATTACHED    = 3'd4;

   // channel modes
   typedef enum logic [2:0] {
      MODE_ON       = 3'd0,
      MODE_ARMED    = 3'd1,
      MODE_HOLD     = 3'd2,
      MODE_RAW      = 3'd3,
      MODE_SLOW     = 3'd4,
      MODE_SLOW_CAL = 3'd5,
      MODE_SLOW_REL = 3'd6,
      MODE_SLOPE    = 3'd7
   } mode_type;

   // configuration registers as seen by the core
   typedef struct packed {
      logic [3:0]  ramp_shift;
      logic [15:0] speed_offset;
      logic [15:0] decel_reference;
      logic [15:0] safe_period;
      logic        generator_attached;
   } cfg_type;

   // one request
   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] target_position;
      logic [15:0]        start_period;
      logic [15:0]        cruise_period;
      logic [15:0]        end_period;
      logic signed [15:0] steps_before_decel;
      logic [14:0]        decel_count;
      logic [2:0]         start_mode;
      logic               start_forward;
   } req_type;

   // one result
   typedef struct packed {
      logic [15:0]        period;
      logic signed [31:0] position;
      logic               running;
      logic               forward;
      mode_type           mode;
      logic               request_slope;
      logic               slope_missed;
      logic               zero_move;
   } rsp_type;

   // mode taken when the step timer stops at the end of a movement
   function automatic mode_type stop_mode(input mode_type    mode,
                                          input logic [15:0] period,
                                          input logic [15:0] safe);
      mode_type m;
      m = mode;
      unique case (mode)
         MODE_RAW:      m = MODE_ON;
         MODE_SLOW_CAL: m = MODE_HOLD;
         MODE_SLOPE:    m = (period < safe) ? MODE_HOLD : MODE_ARMED;
         MODE_SLOW,
         MODE_SLOW_REL: m = MODE_ARMED;
         default:       m = mode;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

FILE: design/srg_req_if.sv
// srg_req_if: request channel of the stepper ramp generator
// valid/ready handshake with the request fields; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface srg_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic signed [31:0] target_position;
   logic [15:0]        start_period;
   logic [15:0]        cruise_period;
   logic [15:0]        end_period;
   logic signed [15:0] steps_before_decel;
   logic [14:0]        decel_count;
   logic [2:0]         start_mode;
   logic               start_forward;

   modport source (
      output valid, op, target_position, start_period, cruise_period, end_period,
             steps_before_decel, decel_count, start_mode, start_forward,
      input  ready
   );
   modport sink (
      input  valid, op, target_position, start_period, cruise_period, end_period,
             steps_before_decel, decel_count, start_mode, start_forward,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/srg_rsp_if.sv
// srg_rsp_if: result channel of the stepper ramp generator
// valid/ready handshake with the result fields; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface srg_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        period;
   logic signed [31:0] position;
   logic               running;
   logic               forward;
   logic [2:0]         mode;
   logic               request_slope;
   logic               slope_missed;
   logic               zero_move;

   modport source (
      output valid, period, position, running, forward, mode,
             request_slope, slope_missed, zero_move,
      input  ready
   );
   modport sink (
      input  valid, period, position, running, forward, mode,
             request_slope, slope_missed, zero_move,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/srg_csr_if.sv
// srg_csr_if: configuration write channel of the stepper ramp generator
// valid/ready handshake with register index and write data; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface srg_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/srg_csr.sv
// srg_csr: configuration registers of the stepper ramp generator
// depends on srg_pkg and srg_csr_if
`timescale 1ns / 1ps
`default_nettype none

module srg_csr (
   input  wire logic       clock,
   input  wire logic       reset,
   srg_csr_if.sink         csr_if,
   output srg_pkg::cfg_type cfg
);

   srg_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;

   // writes are always taken
   assign csr_if.ready = 1'b1;
   assign wr_en        = csr_if.valid;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_if.index)
            srg_pkg::CSR_RAMP_SHIFT:      cfg_in.ramp_shift      = csr_if.data[3:0];
            srg_pkg::CSR_SPEED_OFFSET:    cfg_in.speed_offset    = csr_if.data;
            srg_pkg::CSR_DECEL_REFERENCE: cfg_in.decel_reference = csr_if.data;
            srg_pkg::CSR_SAFE_PERIOD:     cfg_in.safe_period     = csr_if.data;
            srg_pkg::CSR_GEN_ATTACHED:    cfg_in.generator_attached = csr_if.data[0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_shift         <= 4'd4;
         cfg_ff.speed_offset       <= 16'd0;
         cfg_ff.decel_reference    <= 16'd0;
         cfg_ff.safe_period        <= 16'hFFFF;
         cfg_ff.generator_attached <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: design/srg_ramp.sv
// srg_ramp: one trapezoid ramp update of the step timer period
// depends on srg_pkg (configuration struct)
`timescale 1ns / 1ps
`default_nettype none

module srg_ramp (
   input  wire srg_pkg::cfg_type cfg,
   input  wire logic [15:0]      cur_period,
   input  wire logic [15:0]      cur_counter,
   input  wire logic [15:0]      cruise_period,
   input  wire logic [15:0]      end_period,
   input  wire logic [14:0]      decel_len,
   output logic [15:0]           next_period,
   output logic [15:0]           next_counter
);

   logic [15:0]        accel_period;
   logic [15:0]        decel_delta;
   logic signed [15:0] decel_step;
   logic [15:0]        decel_period;

   // counter runs from negative (accelerating) up through the decel steps
   assign next_counter = cur_counter + 16'd1;

   // acceleration: shrink the period by a shifted fraction, add the offset
   assign accel_period = cur_period - (cur_period >> cfg.ramp_shift) + cfg.speed_offset;

   // deceleration: grow by the arithmetically shifted distance from the reference, plus one
   assign decel_delta  = cur_period - cfg.decel_reference + (16'd1 << cfg.ramp_shift);
   assign decel_step   = $signed(decel_delta) >>> cfg.ramp_shift;
   assign decel_period = cur_period + $unsigned(decel_step);

   // phase select and clamps
   always_comb begin
      if (next_counter[15]) begin
         next_period = (accel_period < cruise_period) ? cruise_period : accel_period;
      end else if (next_counter[14:0] <= decel_len) begin
         next_period = (decel_period > end_period) ? end_period : decel_period;
      end else begin
         next_period = end_period;
      end
   end

endmodule

`default_nettype wire

FILE: design/srg_core.sv
// srg_core: channel state, double-buffered slope store and step handling
// depends on srg_pkg and srg_ramp
`timescale 1ns / 1ps
`default_nettype none

module srg_core #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire srg_pkg::req_type req,
   input  wire srg_pkg::cfg_type cfg,
   output srg_pkg::rsp_type      rsp_d
);

   localparam int P = POSITION_BITS;

   // channel state
   logic [P-1:0]      pos_ff, pos_in;
   logic              dir_ff, dir_in;
   logic              run_ff, run_in;
   srg_pkg::mode_type mode_ff, mode_in;
   logic [15:0]       period_ff, period_in;
   logic              act_ff, act_in;
   logic              pend_ff, pend_in;

   // slope double buffer
   logic [P-1:0] target_ff  [2];
   logic [P-1:0] target_in  [2];
   logic [15:0]  start_ff   [2];
   logic [15:0]  start_in   [2];
   logic [15:0]  cruise_ff  [2];
   logic [15:0]  cruise_in  [2];
   logic [15:0]  endp_ff    [2];
   logic [15:0]  endp_in    [2];
   logic [15:0]  counter_ff [2];
   logic [15:0]  counter_in [2];
   logic [14:0]  decel_ff   [2];
   logic [14:0]  decel_in   [2];

   logic              idle_buf;
   logic              is_step;
   logic [P-1:0]      pos_step;
   logic              at_target;
   logic              in_slope;
   logic              swap;
   logic              zero_hit;
   logic              do_stop;
   logic              missed;
   logic              req_flag;
   logic              act_nx;
   logic [15:0]       period_mid;
   srg_pkg::mode_type mode_mid;
   logic              dir_mid;
   logic              do_ramp;
   logic [15:0]       ramp_period;
   logic [15:0]       ramp_counter;
   logic signed [P-1:0] pos_signed;

   assign idle_buf = ~act_ff;
   assign is_step  = fire && (req.op == srg_pkg::OP_STEP) && run_ff;

   // step and end-of-movement detection
   assign pos_step  = dir_ff ? pos_ff + P'(1) : pos_ff - P'(1);
   assign at_target = is_step && (pos_step == target_ff[act_ff]);
   assign in_slope  = (mode_ff == srg_pkg::MODE_SLOPE);
   assign swap      = at_target && in_slope && pend_ff;
   assign zero_hit  = swap && (pos_step == target_ff[idle_buf]);
   assign do_stop   = at_target && (!in_slope || !pend_ff);
   assign missed    = at_target && in_slope && !pend_ff && cfg.generator_attached;
   assign req_flag  = swap && cfg.generator_attached;
   assign act_nx    = act_ff ^ swap;

   // period, mode and direction after the movement-end handling
   assign period_mid = swap ? start_ff[idle_buf] : period_ff;
   assign mode_mid   = do_stop ? srg_pkg::stop_mode(mode_ff, period_ff, cfg.safe_period)
                               : mode_ff;
   assign dir_mid    = (swap && !zero_hit) ?
                       ($signed(target_ff[idle_buf]) > $signed(pos_step)) : dir_ff;
   assign do_ramp    = is_step && !missed && (mode_mid == srg_pkg::MODE_SLOPE);

   srg_ramp u_ramp (
      .cfg           (cfg),
      .cur_period    (period_mid),
      .cur_counter   (counter_ff[act_nx]),
      .cruise_period (cruise_ff[act_nx]),
      .end_period    (endp_ff[act_nx]),
      .decel_len     (decel_ff[act_nx]),
      .next_period   (ramp_period),
      .next_counter  (ramp_counter)
   );

   // next state per request
   always_comb begin
      pos_in     = pos_ff;
      dir_in     = dir_ff;
      run_in     = run_ff;
      mode_in    = mode_ff;
      period_in  = period_ff;
      act_in     = act_ff;
      pend_in    = pend_ff;
      target_in  = target_ff;
      start_in   = start_ff;
      cruise_in  = cruise_ff;
      endp_in    = endp_ff;
      counter_in = counter_ff;
      decel_in   = decel_ff;
      if (fire) begin
         unique case (req.op)
            srg_pkg::OP_LOAD: begin
               target_in[idle_buf]  = req.target_position[P-1:0];
               start_in[idle_buf]   = req.start_period;
               cruise_in[idle_buf]  = req.cruise_period;
               endp_in[idle_buf]    = req.end_period;
               counter_in[idle_buf] = req.steps_before_decel;
               decel_in[idle_buf]   = req.decel_count;
               pend_in              = 1'b1;
            end
            srg_pkg::OP_START: begin
               period_in = req.start_period;
               mode_in   = srg_pkg::mode_type'(req.start_mode);
               dir_in    = req.start_forward;
               run_in    = 1'b1;
            end
            srg_pkg::OP_STEP: begin
               if (run_ff) begin
                  pos_in    = pos_step;
                  dir_in    = dir_mid;
                  run_in    = !(do_stop || zero_hit);
                  mode_in   = mode_mid;
                  act_in    = act_nx;
                  pend_in   = at_target ? 1'b0 : pend_ff;
                  period_in = do_ramp ? ramp_period : period_mid;
                  if (do_ramp) begin
                     counter_in[act_nx] = ramp_counter;
                  end
               end
            end
            default: begin
               pend_in = pend_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         dir_ff     <= 1'b1;
         run_ff     <= 1'b0;
         mode_ff    <= srg_pkg::MODE_ON;
         period_ff  <= '0;
         act_ff     <= 1'b0;
         pend_ff    <= 1'b0;
         target_ff  <= '{default: '0};
         start_ff   <= '{default: '0};
         cruise_ff  <= '{default: '0};
         endp_ff    <= '{default: '0};
         counter_ff <= '{default: '0};
         decel_ff   <= '{default: '0};
      end else begin
         pos_ff     <= pos_in;
         dir_ff     <= dir_in;
         run_ff     <= run_in;
         mode_ff    <= mode_in;
         period_ff  <= period_in;
         act_ff     <= act_in;
         pend_ff    <= pend_in;
         target_ff  <= target_in;
         start_ff   <= start_in;
         cruise_ff  <= cruise_in;
         endp_ff    <= endp_in;
         counter_ff <= counter_in;
         decel_ff   <= decel_in;
      end
   end

   // result reflects the state after the request
   assign pos_signed = pos_in;

   always_comb begin
      rsp_d.period        = period_in;
      rsp_d.position      = 32'(pos_signed);
      rsp_d.running       = run_in;
      rsp_d.forward       = dir_in;
      rsp_d.mode          = mode_in;
      rsp_d.request_slope = req_flag;
      rsp_d.slope_missed  = missed;
      rsp_d.zero_move     = zero_hit;
   end

   // a slope is never both taken and missed at a movement end
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      fire |-> !(rsp_d.request_slope && rsp_d.slope_missed))
      else $error("slope request and slope miss in the same result");

   // a zero-length slope leaves the timer stopped
   a_zero_stops: assert property (@(posedge clock) disable iff (reset)
      fire && rsp_d.zero_move |=> !run_ff)
      else $error("timer still running after zero-length slope");

   // a load always leaves a slope pending
   a_load_pending: assert property (@(posedge clock) disable iff (reset)
      fire && (req.op == srg_pkg::OP_LOAD) |=> pend_ff)
      else $error("no slope pending after load");

   // event flags come only from a running step tick
   a_flags_on_step: assert property (@(posedge clock) disable iff (reset)
      fire && !(req.op == srg_pkg::OP_STEP && run_ff) |->
         !(rsp_d.request_slope || rsp_d.slope_missed || rsp_d.zero_move))
      else $error("event flag outside a running step tick");

   // a missed slope ends the movement in a stopped channel
   a_missed_stops: assert property (@(posedge clock) disable iff (reset)
      fire && rsp_d.slope_missed |=> !run_ff && (mode_ff != srg_pkg::MODE_SLOPE))
      else $error("channel still in slope motion after a missed slope");

endmodule

`default_nettype wire

FILE: design/stepper_ramp_generator.sv
// stepper_ramp_generator: one stepper channel with trapezoid speed ramp
// depends on srg_pkg, the srg_*_if interfaces, srg_csr and srg_core
//
// Usage:
//   req_if carries requests: op 0 is a step tick, op 1 loads a slope into the
//   idle half of the slope double buffer, op 2 starts the step timer with a
//   given period, mode and direction. Every request yields exactly one result
//   on rsp_if: timer period, position, running, direction, mode and the
//   request_slope / slope_missed / zero_move event flags of that request.
//   csr_if writes the ramp configuration registers; it is always ready and
//   should only be written while no request is in flight.
//   Timing: a request is registered on acceptance; once the result register
//   is free or being emptied, the channel state updates and the result
//   register loads, and the result is then valid on rsp_if.
//   Throughput: one request per cycle while the receiver takes results; the
//   state update and ramp step between the two registers are combinational.
//   Reset: position 0, direction forward, timer stopped, mode on, period 0,
//   no slope pending, both slope buffers cleared, registers at their defaults.
//   When the receiver stalls, the result register holds its value and the
//   request register keeps at most one more request; req_if.ready then drops.
`timescale 1ns / 1ps
`default_nettype none

module stepper_ramp_generator #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   srg_req_if.sink   req_if,
   srg_rsp_if.source rsp_if,
   srg_csr_if.sink   csr_if
);

   srg_pkg::cfg_type cfg;
   srg_pkg::req_type req_ff, req_in;
   srg_pkg::rsp_type rsp_ff, rsp_d;
   logic             req_valid_ff, req_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             advance;
   logic             take;

   // request moves on when the result register is free or being emptied
   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !req_valid_ff || advance;
   assign take          = req_if.valid && req_if.ready;
   assign req_valid_in  = take || (req_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_if.ready);

   // request register payload
   always_comb begin
      req_in = req_ff;
      if (take) begin
         req_in.op                 = req_if.op;
         req_in.target_position    = req_if.target_position;
         req_in.start_period       = req_if.start_period;
         req_in.cruise_period      = req_if.cruise_period;
         req_in.end_period         = req_if.end_period;
         req_in.steps_before_decel = req_if.steps_before_decel;
         req_in.decel_count        = req_if.decel_count;
         req_in.start_mode         = req_if.start_mode;
         req_in.start_forward      = req_if.start_forward;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (advance) begin
         rsp_ff <= rsp_d;
      end
   end

   srg_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   srg_core #(
      .POSITION_BITS (POSITION_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp_d (rsp_d)
   );

   // result channel
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.period        = rsp_ff.period;
   assign rsp_if.position      = rsp_ff.position;
   assign rsp_if.running       = rsp_ff.running;
   assign rsp_if.forward       = rsp_ff.forward;
   assign rsp_if.mode          = rsp_ff.mode;
   assign rsp_if.request_slope = rsp_ff.request_slope;
   assign rsp_if.slope_missed  = rsp_ff.slope_missed;
   assign rsp_if.zero_move     = rsp_ff.zero_move;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// testbench: self-checking bench for the stepper ramp generator channel
// depends on srg_pkg, the srg_req_if / srg_rsp_if / srg_csr_if interfaces and the design
// directed table first, then random movements checked against a built-in channel predictor
`timescale 1ns / 1ps

module testbench;

   // op code the block ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 125;

   typedef struct {
      srg_pkg::req_type item;
      bit               typed;
      srg_pkg::rsp_type status;
   } stim_type;

   logic clock = 1'b0;
   logic reset;

   srg_req_if req_if ();
   srg_rsp_if rsp_if ();
   srg_csr_if csr_if ();

   stepper_ramp_generator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #4 clock = ~clock;

   // predicted channel state and registers
   logic [31:0]       ch_position;
   logic              ch_forward;
   logic              ch_running;
   srg_pkg::mode_type ch_mode;
   logic [15:0]       ch_period;
   logic              ch_active;
   logic              ch_pending;
   logic [31:0]       buf_target [2];
   logic [15:0]       buf_start [2];
   logic [15:0]       buf_cruise [2];
   logic [15:0]       buf_end [2];
   logic [15:0]       buf_ramp [2];
   logic [15:0]       buf_decel [2];
   srg_pkg::cfg_type  settings;

   srg_pkg::rsp_type predicted_status [$];
   int      failures = 0;
   int      items_done = 0;
   bit      idling = 1'b1;

   // channel update for one request, returns the status it reports
   function automatic srg_pkg::rsp_type advance_channel(input srg_pkg::req_type r);
      srg_pkg::rsp_type   s;
      logic [15:0]        sp;
      logic [15:0]        t;
      logic signed [15:0] ts;
      logic signed [15:0] delta;
      logic [3:0]         sh;
      logic               b;
      logic               stop;
      logic               skip;
      s = '0;
      stop = 1'b0;
      skip = 1'b0;
      case (r.op)
         srg_pkg::OP_LOAD: begin
            b = ~ch_active;
            buf_target[b] = r.target_position;
            buf_start[b] = r.start_period;
            buf_cruise[b] = r.cruise_period;
            buf_end[b] = r.end_period;
            buf_ramp[b] = r.steps_before_decel;
            buf_decel[b] = {1'b0, r.decel_count};
            ch_pending = 1'b1;
         end
         srg_pkg::OP_START: begin
            ch_period = r.start_period;
            ch_mode = srg_pkg::mode_type'(r.start_mode);
            ch_forward = r.start_forward;
            ch_running = 1'b1;
         end
         srg_pkg::OP_STEP: if (ch_running) begin
            ch_position = ch_forward ? ch_position + 32'd1 : ch_position - 32'd1;
            // end of movement
            if (ch_position == buf_target[ch_active]) begin
               if (ch_mode == srg_pkg::MODE_SLOPE) begin
                  if (ch_pending) begin
                     ch_active = ~ch_active;
                     ch_period = buf_start[ch_active];
                     if (ch_position == buf_target[ch_active]) begin
                        ch_running = 1'b0;
                        s.zero_move = 1'b1;
                     end else begin
                        ch_forward = $signed(buf_target[ch_active]) > $signed(ch_position);
                     end
                  end
                  if (settings.generator_attached) begin
                     if (ch_pending) begin
                        s.request_slope = 1'b1;
                     end else begin
                        s.slope_missed = 1'b1;
                        stop = 1'b1;
                        skip = 1'b1;
                     end
                  end else if (!ch_pending) begin
                     stop = 1'b1;
                  end
               end else begin
                  stop = 1'b1;
               end
               // stop and fall into the follow-up mode
               if (stop) begin
                  ch_running = 1'b0;
                  case (ch_mode)
                     srg_pkg::MODE_RAW:      ch_mode = srg_pkg::MODE_ON;
                     srg_pkg::MODE_SLOW_CAL: ch_mode = srg_pkg::MODE_HOLD;
                     srg_pkg::MODE_SLOPE: begin
                        ch_mode = (ch_period < settings.safe_period) ?
                                  srg_pkg::MODE_HOLD : srg_pkg::MODE_ARMED;
                     end
                     srg_pkg::MODE_SLOW, srg_pkg::MODE_SLOW_REL: ch_mode = srg_pkg::MODE_ARMED;
                     default: ;
                  endcase
               end
               ch_pending = 1'b0;
            end
            // trapezoid ramp step
            if (!skip && ch_mode == srg_pkg::MODE_SLOPE) begin
               b = ch_active;
               sp = ch_period;
               sh = settings.ramp_shift;
               buf_ramp[b] = buf_ramp[b] + 16'd1;
               if (buf_ramp[b][15]) begin
                  sp = sp - (sp >> sh);
                  sp = sp + settings.speed_offset;
                  if (sp < buf_cruise[b]) sp = buf_cruise[b];
               end else if (buf_ramp[b] <= buf_decel[b]) begin
                  t = sp - settings.decel_reference + (16'd1 << sh);
                  ts = t;
                  delta = ts >>> sh;
                  sp = sp + delta;
                  if (sp > buf_end[b]) sp = buf_end[b];
               end else begin
                  sp = buf_end[b];
               end
               ch_period = sp;
            end
         end
         default: ;
      endcase
      s.period = ch_period;
      s.position = ch_position;
      s.running = ch_running;
      s.forward = ch_forward;
      s.mode = ch_mode;
      return s;
   endfunction

   function automatic srg_pkg::req_type request_of(input logic [1:0] op,
                                                   input logic [31:0] tgt,
                                                   input logic [15:0] sp, input logic [15:0] cp,
                                                   input logic [15:0] ep, input logic [15:0] sbd,
                                                   input logic [14:0] dc, input logic [2:0] md,
                                                   input logic fw);
      srg_pkg::req_type r;
      r.op = op;
      r.target_position = tgt;
      r.start_period = sp;
      r.cruise_period = cp;
      r.end_period = ep;
      r.steps_before_decel = sbd;
      r.decel_count = dc;
      r.start_mode = md;
      r.start_forward = fw;
      return r;
   endfunction

   function automatic srg_pkg::rsp_type status_of(input logic [15:0] period,
                                                  input logic [31:0] pos,
                                                  input logic run, input logic fw,
                                                  input srg_pkg::mode_type md);
      srg_pkg::rsp_type s;
      s = '0;
      s.period = period;
      s.position = pos;
      s.running = run;
      s.forward = fw;
      s.mode = md;
      return s;
   endfunction

   // period values with the extremes weighted in
   function automatic logic [15:0] pick_period();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic srg_pkg::req_type random_item();
      srg_pkg::req_type r;
      r.op = 2'($urandom_range(0, 3));
      r.target_position = $urandom;
      r.start_period = pick_period();
      r.cruise_period = pick_period();
      r.end_period = pick_period();
      r.steps_before_decel = 16'($urandom_range(0, 65535));
      r.decel_count = 15'($urandom_range(0, 32767));
      r.start_mode = 3'($urandom_range(0, 7));
      r.start_forward = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // slope that continues from the active target, zero length now and then
   function automatic srg_pkg::req_type slope_load();
      srg_pkg::req_type r;
      int               d;
      r = random_item();
      r.op = srg_pkg::OP_LOAD;
      d = $urandom_range(0, 48) - 24;
      r.target_position = buf_target[ch_active] + 32'(d);
      if ($urandom_range(0, 3) != 0) r.steps_before_decel = -16'($urandom_range(0, 40));
      if ($urandom_range(0, 3) != 0) r.decel_count = 15'($urandom_range(0, 40));
      return r;
   endfunction

   // one request on the input channel, with an optional gap in front
   task automatic push_request(input srg_pkg::req_type r, input bit typed,
                               input srg_pkg::rsp_type status);
      srg_pkg::rsp_type s;
      if (idling && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op <= r.op;
      req_if.target_position <= r.target_position;
      req_if.start_period <= r.start_period;
      req_if.cruise_period <= r.cruise_period;
      req_if.end_period <= r.end_period;
      req_if.steps_before_decel <= r.steps_before_decel;
      req_if.decel_count <= r.decel_count;
      req_if.start_mode <= r.start_mode;
      req_if.start_forward <= r.start_forward;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_done++;
      s = advance_channel(r);
      predicted_status.push_back(typed ? status : s);
   endtask

   // drain everything outstanding
   task automatic settle();
      req_if.valid <= 1'b0;
      while (predicted_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input srg_pkg::cfg_type c);
      logic [2:0]  idx;
      logic [15:0] val;
      for (int i = 0; i < 5; i++) begin
         case (i)
            0: begin idx = srg_pkg::CSR_RAMP_SHIFT; val = {12'd0, c.ramp_shift}; end
            1: begin idx = srg_pkg::CSR_SPEED_OFFSET; val = c.speed_offset; end
            2: begin idx = srg_pkg::CSR_DECEL_REFERENCE; val = c.decel_reference; end
            3: begin idx = srg_pkg::CSR_SAFE_PERIOD; val = c.safe_period; end
            default: begin
               idx = srg_pkg::CSR_GEN_ATTACHED;
               val = {15'd0, c.generator_attached};
            end
         endcase
         csr_if.valid <= 1'b1;
         csr_if.index <= idx;
         csr_if.data <= val;
         @(posedge clock);
         while (!csr_if.ready) @(posedge clock);
      end
      csr_if.valid <= 1'b0;
      settings = c;
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      srg_pkg::rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (predicted_status.size() == 0) begin
            $error("result with no request outstanding");
            failures++;
         end else begin
            want = predicted_status.pop_front();
            check_field("period", want.period, rsp_if.period);
            check_field("position", want.position, rsp_if.position);
            check_field("running", want.running, rsp_if.running);
            check_field("forward", want.forward, rsp_if.forward);
            check_field("mode", want.mode, rsp_if.mode);
            check_field("request_slope", want.request_slope, rsp_if.request_slope);
            check_field("slope_missed", want.slope_missed, rsp_if.slope_missed);
            check_field("zero_move", want.zero_move, rsp_if.zero_move);
         end
      end
   end

   // receiver stalls in bursts
   initial begin
      rsp_if.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idling && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   // stimulus
   initial begin
      stim_type         directed_rows [23];
      srg_pkg::rsp_type at_rest;
      srg_pkg::req_type r;
      srg_pkg::cfg_type c;
      int               roll;

      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.op <= srg_pkg::OP_STEP;
      req_if.target_position <= '0;
      req_if.start_period <= '0;
      req_if.cruise_period <= '0;
      req_if.end_period <= '0;
      req_if.steps_before_decel <= '0;
      req_if.decel_count <= '0;
      req_if.start_mode <= '0;
      req_if.start_forward <= 1'b0;
      csr_if.valid <= 1'b0;
      csr_if.index <= srg_pkg::CSR_RAMP_SHIFT;
      csr_if.data <= '0;

      // predictor at its reset state
      ch_position = '0;
      ch_forward = 1'b1;
      ch_running = 1'b0;
      ch_mode = srg_pkg::MODE_ON;
      ch_period = '0;
      ch_active = 1'b0;
      ch_pending = 1'b0;
      for (int i = 0; i < 2; i++) begin
         buf_target[i] = '0;
         buf_start[i] = '0;
         buf_cruise[i] = '0;
         buf_end[i] = '0;
         buf_ramp[i] = '0;
         buf_decel[i] = '0;
      end
      settings = '{ramp_shift: 4'd4, speed_offset: 16'd0, decel_reference: 16'd0,
                   safe_period: 16'hFFFF, generator_attached: 1'b0};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      at_rest = status_of(16'd0, 32'd0, 1'b0, 1'b1, srg_pkg::MODE_ON);
      directed_rows = '{
         // tick while stopped, unused op with every field at its top
         '{request_of(srg_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, srg_pkg::MODE_ON, 0), 1'b1, at_rest},
         '{request_of(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      15'h7FFF, srg_pkg::MODE_SLOPE, 1), 1'b1, at_rest},
         // load, then load again while pending
         '{request_of(srg_pkg::OP_LOAD, 5, 1000, 200, 2000, -16'sd3, 2, srg_pkg::MODE_ON, 0),
           1'b1, at_rest},
         '{request_of(srg_pkg::OP_LOAD, 4, 1200, 300, 1500, -16'sd2, 1, srg_pkg::MODE_ON, 0),
           1'b1, at_rest},
         '{request_of(srg_pkg::OP_START, 0, 16'hFFFF, 0, 0, 0, 0, srg_pkg::MODE_RAW, 1), 1'b1,
           status_of(16'hFFFF, 32'd0, 1'b1, 1'b1, srg_pkg::MODE_RAW)},
         '{request_of(srg_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, srg_pkg::MODE_ON, 0), 1'b1,
           status_of(16'hFFFF, 32'd1, 1'b1, 1'b1, srg_pkg::MODE_RAW)},
         '{request_of(srg_pkg::OP_START, 0, 800, 0, 0, 0, 0, srg_pkg::MODE_SLOPE, 0), 1'b1,
           status_of(16'd800, 32'd1, 1'b1, 1'b0, srg_pkg::MODE_SLOPE)},
         // slope swap with request, ramp, then slope missed at the end
         '{request_of(srg_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, srg_pkg::MODE_ON, 0), 1'b0, '0},
         '{request_of(srg_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, srg_pkg::MODE_ON, 0), 1'b0, '0},
         '{request_of(srg_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, srg_pkg::MODE_ON, 0), 1'b0, '0},
         '{request_of(srg_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, srg_pkg::MODE_ON, 0), 1'b0, '0},
         '{request_of(srg_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, srg_pkg::MODE_ON, 0), 1'b0, '0},
         // zero-length slope stops the timer
         '{request_of(srg_pkg::OP_LOAD, 4, 0, 0, 16'hFFFF, 16'sh7FFF, 15'h7FFF,
                      srg_pkg::MODE_ON, 0), 1'b0, '0},
         '{request_of(srg_pkg::OP_START, 0, 0, 0, 0, 0, 0, srg_pkg::MODE_SLOPE, 0), 1'b0, '0},
         '{request_of(srg_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, srg_pkg::MODE_ON, 0), 1'b0, '0},
         '{request_of(srg_pkg::OP_START, 0, 0, 0, 0, 0, 0, srg_pkg::MODE_SLOPE, 1), 1'b0, '0},
         '{request_of(srg_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, srg_pkg::MODE_ON, 0), 1'b0, '0},
         '{request_of(srg_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, srg_pkg::MODE_ON, 0), 1'b0, '0},
         // other field extremes, stop out of slow_cal
         '{request_of(srg_pkg::OP_LOAD, 32'h8000_0000, 16'h8000, 16'hFFFF, 0, 16'h8000, 0,
                      srg_pkg::MODE_ON, 0), 1'b0, '0},
         '{request_of(srg_pkg::OP_START, 0, 1, 0, 0, 0, 0, srg_pkg::MODE_SLOW, 1), 1'b0, '0},
         '{request_of(srg_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, srg_pkg::MODE_ON, 0), 1'b0, '0},
         '{request_of(srg_pkg::OP_START, 0, 16'h8000, 0, 0, 0, 0, srg_pkg::MODE_SLOW_CAL, 0),
           1'b0, '0},
         '{request_of(srg_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, srg_pkg::MODE_ON, 0), 1'b0, '0}
      };

      write_settings('{ramp_shift: 4'd2, speed_offset: 16'd16, decel_reference: 16'd100,
                       safe_period: 16'd500, generator_attached: 1'b1});
      foreach (directed_rows[i])
         push_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].status);

      // random movements, one register setting per phase
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: c = '{ramp_shift: 4'd0, speed_offset: 16'd0, decel_reference: 16'd0,
                     safe_period: 16'd0, generator_attached: 1'b0};
            1: c = '{ramp_shift: 4'd15, speed_offset: 16'hFFFF, decel_reference: 16'hFFFF,
                     safe_period: 16'hFFFF, generator_attached: 1'b1};
            2: c = '{ramp_shift: 4'd4, speed_offset: 16'd0, decel_reference: 16'd0,
                     safe_period: 16'hFFFF, generator_attached: 1'b0};
            default: begin
               c.ramp_shift = 4'($urandom_range(0, 15));
               c.speed_offset = 16'($urandom_range(0, 65535));
               c.decel_reference = 16'($urandom_range(0, 65535));
               c.safe_period = 16'($urandom_range(0, 65535));
               c.generator_attached = 1'($urandom_range(0, 1));
            end
         endcase
         write_settings(c);
         idling = (phase != 3) && (phase != PHASES - 1);
         items_done = 0;
         while (items_done < ITEMS_PER_PHASE) begin
            // next slope, start toward the active target
            if (ch_pending || $urandom_range(0, 99) < 80)
               push_request(slope_load(), 1'b0, '0);
            if (!ch_running || $urandom_range(0, 9) == 0) begin
               r = random_item();
               r.op = srg_pkg::OP_START;
               if ($urandom_range(0, 3) != 0) r.start_mode = srg_pkg::MODE_SLOPE;
               if (buf_target[ch_active] != ch_position && $urandom_range(0, 9) != 0)
                  r.start_forward = $signed(buf_target[ch_active]) > $signed(ch_position);
               push_request(r, 1'b0, '0);
            end
            // ticks with the odd reload and some noise
            repeat ($urandom_range(1, 40)) begin
               roll = $urandom_range(0, 99);
               if (roll < 5) begin
                  r = random_item();
                  push_request(r, 1'b0, '0);
                  if (r.op == srg_pkg::OP_LOAD) push_request(slope_load(), 1'b0, '0);
               end else if (roll < 12) begin
                  push_request(slope_load(), 1'b0, '0);
               end else begin
                  r = random_item();
                  r.op = srg_pkg::OP_STEP;
                  push_request(r, 1'b0, '0);
               end
            end
         end
      end

      settle();
      if (failures == 0 && predicted_status.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
design/srg_pkg.sv
design/srg_req_if.sv
design/srg_rsp_if.sv
design/srg_csr_if.sv
design/srg_csr.sv
design/srg_ramp.sv
design/srg_core.sv
design/stepper_ramp_generator.sv
dv/testbench.sv
